### hw/rtl/b2d_pkg.sv
package b2d_pkg;

  localparam int VALUE_W  = 64;
  localparam int CHAR_W   = 6;
  localparam int K_W      = 5;
  localparam int ROW_W    = 68;
  localparam int K_MAX    = 19;
  localparam int DIG_MAX  = 9;
  localparam int Q_DEPTH  = 2;
  localparam int Q_PTR_W  = 1;
  localparam int Q_CNT_W  = 2;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
  localparam logic [CHAR_W-1:0] ASCII_NINE = 6'd57;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [K_W-1:0]     top_k;
  } q_entry_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } back_state_t;

  function automatic logic [VALUE_W-1:0] pow10(input logic [K_W-1:0] k);
    logic [VALUE_W-1:0] p;
    case (k)
      5'd0:    p = 64'd1;
      5'd1:    p = 64'd10;
      5'd2:    p = 64'd100;
      5'd3:    p = 64'd1000;
      5'd4:    p = 64'd10000;
      5'd5:    p = 64'd100000;
      5'd6:    p = 64'd1000000;
      5'd7:    p = 64'd10000000;
      5'd8:    p = 64'd100000000;
      5'd9:    p = 64'd1000000000;
      5'd10:   p = 64'd10000000000;
      5'd11:   p = 64'd100000000000;
      5'd12:   p = 64'd1000000000000;
      5'd13:   p = 64'd10000000000000;
      5'd14:   p = 64'd100000000000000;
      5'd15:   p = 64'd1000000000000000;
      5'd16:   p = 64'd10000000000000000;
      5'd17:   p = 64'd100000000000000000;
      5'd18:   p = 64'd1000000000000000000;
      5'd19:   p = 64'd10000000000000000000;
      default: p = 64'd1;
    endcase
    return p;
  endfunction

endpackage

### hw/rtl/b2d_front.sv
module b2d_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [b2d_pkg::VALUE_W-1:0] in_value,
  output logic                       push,
  output b2d_pkg::q_entry_t          push_data,
  input  logic                       q_full
);

  logic                        fv_r, fv_nxt;
  logic [b2d_pkg::VALUE_W-1:0] value_r;
  logic                        accept;
  logic [b2d_pkg::K_W-1:0]     top_k;

  assign in_stall = fv_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = fv_r && !q_full;

  // number of digits minus one
  always_comb begin
    top_k = '0;
    for (int k = 1; k <= b2d_pkg::K_MAX; k++) begin
      if (value_r >= b2d_pkg::pow10(b2d_pkg::K_W'(k))) begin
        top_k = b2d_pkg::K_W'(k);
      end
    end
  end

  assign push_data.value = value_r;
  assign push_data.top_k = top_k;

  always_comb begin
    fv_nxt = fv_r;
    if (accept) begin
      fv_nxt = 1'b1;
    end else if (push) begin
      fv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value_r <= in_value;
    end
  end

endmodule

### hw/rtl/b2d_queue.sv
module b2d_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  b2d_pkg::q_entry_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              q_valid,
  output b2d_pkg::q_entry_t head
);

  b2d_pkg::q_entry_t              mem_r [b2d_pkg::Q_DEPTH];
  logic [b2d_pkg::Q_PTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [b2d_pkg::Q_CNT_W-1:0]    cnt_r, cnt_nxt;

  assign full    = (cnt_r == b2d_pkg::Q_CNT_W'(b2d_pkg::Q_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### hw/rtl/b2d_back.sv
module b2d_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  b2d_pkg::q_entry_t           head,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [b2d_pkg::CHAR_W-1:0]  out_digit_char,
  output logic                        out_last_digit
);

  b2d_pkg::back_state_t          state_r, state_nxt;
  logic [b2d_pkg::VALUE_W-1:0]   rem_r, rem_nxt;
  logic [b2d_pkg::K_W-1:0]       k_r, k_nxt;
  logic [b2d_pkg::ROW_W-1:0]     row_r [1:b2d_pkg::DIG_MAX];
  logic [b2d_pkg::ROW_W-1:0]     row_nxt [1:b2d_pkg::DIG_MAX];
  logic [b2d_pkg::K_W-1:0]       row_k;
  logic                          row_load;
  logic                          ov_r, ov_nxt;
  logic [b2d_pkg::CHAR_W-1:0]    oc_r;
  logic                          ol_r;
  logic                          step;
  logic [3:0]                    dig;
  logic [b2d_pkg::VALUE_W-1:0]   rem_sub;
  logic [b2d_pkg::ROW_W:0]       diff [1:b2d_pkg::DIG_MAX];

  assign out_valid      = ov_r;
  assign out_digit_char = oc_r;
  assign out_last_digit = ol_r;

  assign step = (state_r == b2d_pkg::ST_RUN) && (!ov_r || !out_stall);

  // largest multiple of the current power that fits
  always_comb begin
    dig     = '0;
    rem_sub = rem_r;
    for (int m = 1; m <= b2d_pkg::DIG_MAX; m++) begin
      diff[m] = {1'b0, (b2d_pkg::ROW_W - b2d_pkg::VALUE_W)'(0), rem_r} - {1'b0, row_r[m]};
      if (!diff[m][b2d_pkg::ROW_W]) begin
        dig     = 4'(m);
        rem_sub = diff[m][b2d_pkg::VALUE_W-1:0];
      end
    end
  end

  always_comb begin
    for (int m = 1; m <= b2d_pkg::DIG_MAX; m++) begin
      row_nxt[m] = b2d_pkg::ROW_W'(b2d_pkg::pow10(row_k)) * b2d_pkg::ROW_W'(m);
    end
  end

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    k_nxt     = k_r;
    row_k     = k_r;
    row_load  = 1'b0;
    pop       = 1'b0;
    ov_nxt    = ov_r && out_stall;
    case (state_r)
      b2d_pkg::ST_IDLE: begin
        if (q_valid) begin
          pop       = 1'b1;
          rem_nxt   = head.value;
          k_nxt     = head.top_k;
          row_k     = head.top_k;
          row_load  = 1'b1;
          state_nxt = b2d_pkg::ST_RUN;
        end
      end
      b2d_pkg::ST_RUN: begin
        if (step) begin
          ov_nxt  = 1'b1;
          rem_nxt = rem_sub;
          if (k_r == '0) begin
            state_nxt = b2d_pkg::ST_IDLE;
          end else begin
            k_nxt    = k_r - 1'b1;
            row_k    = k_r - 1'b1;
            row_load = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = b2d_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= b2d_pkg::ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    k_r   <= k_nxt;
    if (row_load) begin
      for (int m = 1; m <= b2d_pkg::DIG_MAX; m++) begin
        row_r[m] <= row_nxt[m];
      end
    end
    if (step) begin
      oc_r <= b2d_pkg::ASCII_ZERO + b2d_pkg::CHAR_W'(dig);
      ol_r <= (k_r == '0);
    end
  end

`ifndef ASSERT_OFF
  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == b2d_pkg::ST_RUN |-> k_r <= b2d_pkg::K_W'(b2d_pkg::K_MAX))
    else $error("digit position out of range");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == b2d_pkg::ST_RUN |->
      {4'b0, rem_r} < b2d_pkg::ROW_W'(b2d_pkg::pow10(k_r)) * b2d_pkg::ROW_W'(10))
    else $error("remainder exceeds current decade");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (oc_r >= b2d_pkg::ASCII_ZERO && oc_r <= b2d_pkg::ASCII_NINE))
    else $error("non-digit character");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    step && k_r == '0 |=> state_r == b2d_pkg::ST_IDLE && ov_r && ol_r)
    else $error("final digit not flagged");
`endif

endmodule

### hw/rtl/binary_to_decimal_ascii.sv
// Path: input register, queue, digit engine, registered digit output.
// Throughput: one digit per cycle while out_stall is low, from one shared
//   compare/subtract bank; a load step precedes each value's 1 to 20 digits.
// A 2-entry queue decouples input classification from digit generation.
// Reset: synchronous active-low rst_n clears all valid and control state.
module binary_to_decimal_ascii (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [b2d_pkg::VALUE_W-1:0] in_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [b2d_pkg::CHAR_W-1:0]  out_digit_char,
  output logic                        out_last_digit
);

  logic              push, q_full, pop, q_valid;
  b2d_pkg::q_entry_t push_data, head;

  b2d_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_value  (in_value),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  b2d_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .head      (head)
  );

  b2d_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit)
  );

endmodule
